FILE: src/payload_signature_scorer_top_macros.svh
// assertion macros shared by the scorer modules
// each macro expects aclk and aresetn in the scope where it is used
`ifndef PAYLOAD_SIGNATURE_SCORER_TOP_MACROS_SVH
`define PAYLOAD_SIGNATURE_SCORER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// consequent must hold in the same cycle as the antecedent
`define PSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("scorer check failed");

// consequent must hold in the cycle after the antecedent
`define PSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("scorer check failed");

`else

`define PSS_ASSERT_NOW(label, ante, cons)
`define PSS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: src/pss_pkg.sv
package pss_pkg;

    // window and needle geometry
    localparam int unsigned WINDOW_BYTES = 25;
    localparam int unsigned VIEW_BYTES   = WINDOW_BYTES + 1;
    localparam int unsigned WINDOW_BITS  = WINDOW_BYTES * 8;
    localparam int unsigned VIEW_BITS    = VIEW_BYTES * 8;
    localparam int unsigned NEEDLE_COUNT = 12;

    // configuration register
    localparam int unsigned LIMIT_WIDTH = 20;
    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(64 * 1024);
    localparam int unsigned APB_ADDR_WIDTH = 3;
    localparam int unsigned APB_DATA_WIDTH = 32;
    localparam logic REG_LARGE_SIZE_LIMIT = 1'b0;

    // score values
    localparam int unsigned SCORE_WIDTH  = 7;
    localparam int unsigned REASON_WIDTH = 4;
    localparam logic [SCORE_WIDTH-1:0] SCORE_MAX         = 7'd100;
    localparam logic [SCORE_WIDTH-1:0] SCORE_HARD_RULE   = 7'd100;
    localparam logic [SCORE_WIDTH-1:0] SCORE_TRAVERSAL   = 7'd45;
    localparam logic [SCORE_WIDTH-1:0] SCORE_AMBIGUITY   = 7'd70;
    localparam logic [SCORE_WIDTH-1:0] SCORE_CONSEQUENCE = 7'd80;
    localparam logic [SCORE_WIDTH-1:0] SCORE_SIGNATURE   = 7'd100;
    localparam logic [SCORE_WIDTH-1:0] SCORE_NOVELTY     = 7'd20;

    // reason bit positions
    localparam int unsigned REASON_TRAVERSAL = 0;
    localparam int unsigned REASON_COMMAND   = 1;
    localparam int unsigned REASON_PROTOCOL  = 2;
    localparam int unsigned REASON_SIGNATURE = 3;

    // needle groups over the found flags
    localparam logic [NEEDLE_COUNT-1:0] GROUP_TRAVERSAL = 12'h007;
    localparam logic [NEEDLE_COUNT-1:0] GROUP_COMMAND   = 12'h078;
    localparam logic [NEEDLE_COUNT-1:0] GROUP_PROTOCOL  = 12'h180;
    localparam logic [NEEDLE_COUNT-1:0] GROUP_SIGNATURE = 12'hE00;

    // needles, right aligned: last character in the low byte
    localparam logic [VIEW_BITS-1:0] NEEDLE_TEXT [NEEDLE_COUNT] = '{
        VIEW_BITS'("../"),
        VIEW_BITS'("..%2f"),
        VIEW_BITS'("%2e%2e"),
        VIEW_BITS'("cmd.exe"),
        VIEW_BITS'("powershell"),
        VIEW_BITS'("/bin/sh"),
        VIEW_BITS'("mshta"),
        VIEW_BITS'("content-length:"),
        VIEW_BITS'("transfer-encoding: chunked"),
        VIEW_BITS'("jndi:ldap"),
        VIEW_BITS'("meterpreter"),
        VIEW_BITS'("mimikatz")
    };

    localparam int unsigned NEEDLE_LEN [NEEDLE_COUNT] = '{
        3, 5, 6, 7, 10, 7, 5, 15, 26, 9, 11, 8
    };

    // byte mask covering the newest len bytes of the view
    function automatic logic [VIEW_BITS-1:0] needle_mask(input int unsigned len);
        logic [VIEW_BITS-1:0] m;
        m = '0;
        for (int unsigned j = 0; j < VIEW_BYTES; j++) begin
            if (j < len) begin
                m[8*j +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last_byte;
    } pss_item_t;

    typedef struct packed {
        logic [SCORE_WIDTH-1:0]  hard_rule_score;
        logic [SCORE_WIDTH-1:0]  protocol_score;
        logic [SCORE_WIDTH-1:0]  consequence_score;
        logic [SCORE_WIDTH-1:0]  signature_score;
        logic [SCORE_WIDTH-1:0]  novelty_score;
        logic [REASON_WIDTH-1:0] reason_bits;
    } pss_result_t;

endpackage

FILE: src/pss_regs.sv
module pss_regs (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pss_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  logic [pss_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic [pss_pkg::APB_DATA_WIDTH-1:0]   prdata,
    output logic                                 pready,
    output logic [pss_pkg::LIMIT_WIDTH-1:0]      large_size_limit
);

    logic [pss_pkg::LIMIT_WIDTH-1:0] limit_reg;
    logic [pss_pkg::LIMIT_WIDTH-1:0] limit_next;
    logic                            reg_index;

    assign reg_index = paddr[2];
    assign pready    = 1'b1;

    // register write on the access phase
    always_comb begin
        limit_next = limit_reg;
        if (psel && penable && pwrite && pready
                && reg_index == pss_pkg::REG_LARGE_SIZE_LIMIT) begin
            limit_next = pwdata[pss_pkg::LIMIT_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= pss_pkg::LIMIT_RESET;
        end else begin
            limit_reg <= limit_next;
        end
    end

    // read back
    always_comb begin
        case (reg_index)
            pss_pkg::REG_LARGE_SIZE_LIMIT: begin
                prdata = pss_pkg::APB_DATA_WIDTH'(limit_reg);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign large_size_limit = limit_reg;

endmodule

FILE: src/pss_match.sv
`include "payload_signature_scorer_top_macros.svh"

module pss_match #(
    parameter int COUNT_WIDTH = 21
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             accept,
    input  pss_pkg::pss_item_t               item,
    input  logic [pss_pkg::LIMIT_WIDTH-1:0]  large_size_limit,
    output pss_pkg::pss_result_t             result
);

    localparam int CMP_WIDTH = (COUNT_WIDTH > pss_pkg::LIMIT_WIDTH) ?
                               COUNT_WIDTH : pss_pkg::LIMIT_WIDTH;

    logic [pss_pkg::WINDOW_BITS-1:0]  window_reg;
    logic [pss_pkg::WINDOW_BITS-1:0]  window_next;
    logic [pss_pkg::NEEDLE_COUNT-1:0] found_reg;
    logic [pss_pkg::NEEDLE_COUNT-1:0] found_next;
    logic [COUNT_WIDTH-1:0]           count_reg;
    logic [COUNT_WIDTH-1:0]           count_next;

    logic [7:0]                       folded;
    logic [pss_pkg::VIEW_BITS-1:0]    view;
    logic [pss_pkg::NEEDLE_COUNT-1:0] hit;
    logic                             trav;
    logic                             cmd;
    logic                             proto;
    logic                             sig;
    logic [pss_pkg::SCORE_WIDTH:0]    proto_sum;

    // lowercase only A to Z
    always_comb begin
        folded = item.payload_byte;
        if (item.payload_byte inside {[8'h41:8'h5A]}) begin
            folded = item.payload_byte + 8'h20;
        end
    end

    // newest byte sits in the low byte of the view
    assign view = {window_reg, folded};

    // one comparator per needle over the newest needle-length bytes of the view
    for (genvar k = 0; k < pss_pkg::NEEDLE_COUNT; k++) begin : g_needle
        localparam logic [pss_pkg::VIEW_BITS-1:0] MASK =
            pss_pkg::needle_mask(pss_pkg::NEEDLE_LEN[k]);
        assign hit[k] = ((view ^ pss_pkg::NEEDLE_TEXT[k]) & MASK) == '0;
    end

    // sticky flags and saturating count including this item
    assign found_next = found_reg | hit;
    assign count_next = (&count_reg) ? count_reg : count_reg + 1'b1;
    assign window_next = view[pss_pkg::WINDOW_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
            found_reg  <= '0;
            count_reg  <= '0;
        end else if (accept) begin
            if (item.last_byte) begin
                window_reg <= '0;
                found_reg  <= '0;
                count_reg  <= '0;
            end else begin
                window_reg <= window_next;
                found_reg  <= found_next;
                count_reg  <= count_next;
            end
        end
    end

    // group decisions
    assign trav  = (found_next & pss_pkg::GROUP_TRAVERSAL) != '0;
    assign cmd   = (found_next & pss_pkg::GROUP_COMMAND) != '0;
    assign proto = (found_next & pss_pkg::GROUP_PROTOCOL) == pss_pkg::GROUP_PROTOCOL;
    assign sig   = (found_next & pss_pkg::GROUP_SIGNATURE) != '0;

    assign proto_sum = (trav  ? {1'b0, pss_pkg::SCORE_TRAVERSAL} : '0)
                     + (proto ? {1'b0, pss_pkg::SCORE_AMBIGUITY} : '0);

    // scores for the payload that ends with this item
    always_comb begin
        result.hard_rule_score   = (trav || cmd) ? pss_pkg::SCORE_HARD_RULE : '0;
        result.protocol_score    = (proto_sum > {1'b0, pss_pkg::SCORE_MAX}) ?
                                   pss_pkg::SCORE_MAX :
                                   proto_sum[pss_pkg::SCORE_WIDTH-1:0];
        result.consequence_score = cmd ? pss_pkg::SCORE_CONSEQUENCE : '0;
        result.signature_score   = sig ? pss_pkg::SCORE_SIGNATURE : '0;
        result.novelty_score     = (CMP_WIDTH'(count_next) > CMP_WIDTH'(large_size_limit)) ?
                                   pss_pkg::SCORE_NOVELTY : '0;
        result.reason_bits = '0;
        result.reason_bits[pss_pkg::REASON_TRAVERSAL] = trav;
        result.reason_bits[pss_pkg::REASON_COMMAND]   = cmd;
        result.reason_bits[pss_pkg::REASON_PROTOCOL]  = proto;
        result.reason_bits[pss_pkg::REASON_SIGNATURE] = sig;
    end

    // payload state is empty after the last item
    `PSS_ASSERT_NEXT(a_clear_after_last, accept && item.last_byte,
                     found_reg == '0 && count_reg == '0 && window_reg == '0)
    // an accepted non-last item always leaves a nonzero count
    `PSS_ASSERT_NEXT(a_count_moves, accept && !item.last_byte, count_reg != '0)

endmodule

FILE: src/payload_signature_scorer_top.sv
// Payload signature scorer. Payload bytes enter on s_item one per clock;
// every byte is case folded and checked together with the 25 bytes before
// it against twelve fixed needles combinationally, so the sustained rate is
// one byte per clock. The item marked last_byte produces one result in the
// output register, visible on m_item the cycle after it is accepted. The only
// input stall comes from that output register: s_ready is low while a result
// waits and m_ready is low. large_size_limit (APB offset 0x0, reset 65536)
// sets the byte count above which the novelty score is raised.
`include "payload_signature_scorer_top_macros.svh"

module payload_signature_scorer_top #(
    parameter int COUNT_WIDTH = 21
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  pss_pkg::pss_item_t                   s_item,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output pss_pkg::pss_result_t                 m_item,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pss_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  logic [pss_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic [pss_pkg::APB_DATA_WIDTH-1:0]   prdata,
    output logic                                 pready
);

    logic                            s_accept;
    logic [pss_pkg::LIMIT_WIDTH-1:0] large_size_limit;
    pss_pkg::pss_result_t            result;
    pss_pkg::pss_result_t            m_item_reg;
    logic                            m_valid_reg;
    logic                            m_valid_next;

    // configuration registers
    pss_regs u_regs (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .large_size_limit (large_size_limit)
    );

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    // window, needle compare and scoring
    pss_match #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_match (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .accept           (s_accept),
        .item             (s_item),
        .large_size_limit (large_size_limit),
        .result           (result)
    );

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_accept && s_item.last_byte) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && s_item.last_byte) begin
            m_item_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // a last item always leaves a result behind
    `PSS_ASSERT_NEXT(a_last_gives_result, s_accept && s_item.last_byte, m_valid)
    // hard rule score follows the traversal and command reasons
    `PSS_ASSERT_NOW(a_hard_rule_reason, m_valid,
                    (m_item.hard_rule_score != '0) ==
                    (m_item.reason_bits[pss_pkg::REASON_TRAVERSAL] ||
                     m_item.reason_bits[pss_pkg::REASON_COMMAND]))
    // protocol score follows the traversal and ambiguity reasons
    `PSS_ASSERT_NOW(a_protocol_reason, m_valid,
                    (m_item.protocol_score != '0) ==
                    (m_item.reason_bits[pss_pkg::REASON_TRAVERSAL] ||
                     m_item.reason_bits[pss_pkg::REASON_PROTOCOL]))

endmodule

FILE: tb/sv/payload_signature_scorer_top_tb.sv
`timescale 1ns / 100ps

module payload_signature_scorer_top_tb;

    localparam int unsigned COUNT_W = 21;

    // register map
    localparam logic [pss_pkg::APB_ADDR_WIDTH-1:0] ADDR_SIZE_LIMIT = 3'd0;
    localparam logic [pss_pkg::APB_ADDR_WIDTH-1:0] ADDR_UNMAPPED   = 3'd4;

    // needle indexes that only score as a pair
    localparam int unsigned NEEDLE_CONTENT_LENGTH    = 7;
    localparam int unsigned NEEDLE_TRANSFER_ENCODING = 8;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    pss_pkg::pss_item_t s_item = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    pss_pkg::pss_result_t m_item;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [pss_pkg::APB_ADDR_WIDTH-1:0] paddr = '0;
    logic [pss_pkg::APB_DATA_WIDTH-1:0] pwdata = '0;
    logic [pss_pkg::APB_DATA_WIDTH-1:0] prdata;
    logic pready;

    bit sender_gaps = 1'b1;
    bit receiver_gaps = 1'b1;
    int unsigned bytes_sent = 0;
    int unsigned payloads_sent = 0;
    int unsigned limits_used = 0;

    payload_signature_scorer_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // tracks the scorer state and the scores still owed
    class score_board;
        logic [7:0] recent [pss_pkg::WINDOW_BYTES];
        logic [pss_pkg::NEEDLE_COUNT-1:0] found;
        logic [COUNT_W-1:0] seen_count;
        logic [pss_pkg::LIMIT_WIDTH-1:0] size_limit;
        pss_pkg::pss_result_t pending_scores [$];
        int unsigned faults;

        function new();
            faults = 0;
            size_limit = 20'd65536;
            clear_payload();
        endfunction

        function void clear_payload();
            for (int i = 0; i < pss_pkg::WINDOW_BYTES; i++) begin
                recent[i] = 8'h00;
            end
            found = '0;
            seen_count = '0;
        endfunction

        function string needle_text(int unsigned k);
            case (k)
                0: return "../";
                1: return "..%2f";
                2: return "%2e%2e";
                3: return "cmd.exe";
                4: return "powershell";
                5: return "/bin/sh";
                6: return "mshta";
                7: return "content-length:";
                8: return "transfer-encoding: chunked";
                9: return "jndi:ldap";
                10: return "meterpreter";
                default: return "mimikatz";
            endcase
        endfunction

        function void write_reg(logic [pss_pkg::APB_ADDR_WIDTH-1:0] addr, logic [31:0] data);
            if (addr == ADDR_SIZE_LIMIT) begin
                size_limit = data[pss_pkg::LIMIT_WIDTH-1:0];
            end
        endfunction

        // shift one folded byte in, update flags and count, score on the last byte
        function void absorb_byte(pss_pkg::pss_item_t it);
            logic [7:0] view [pss_pkg::VIEW_BYTES];
            logic [7:0] c;
            string n;
            int unsigned len;
            bit hit;
            bit trav, cmd, proto, sig;
            int unsigned proto_sum;
            pss_pkg::pss_result_t want;
            c = it.payload_byte;
            // only 'A'..'Z' fold
            if (c >= 8'h41 && c <= 8'h5A) begin
                c = c + 8'd32;
            end
            for (int i = 0; i < pss_pkg::WINDOW_BYTES; i++) begin
                view[i] = recent[i];
            end
            view[pss_pkg::WINDOW_BYTES] = c;
            for (int k = 0; k < pss_pkg::NEEDLE_COUNT; k++) begin
                n = needle_text(k);
                len = n.len();
                hit = 1'b1;
                for (int i = 0; i < len; i++) begin
                    if (view[pss_pkg::VIEW_BYTES - len + i] != n[i]) begin
                        hit = 1'b0;
                    end
                end
                if (hit) begin
                    found[k] = 1'b1;
                end
            end
            for (int i = 0; i < pss_pkg::WINDOW_BYTES; i++) begin
                recent[i] = view[i+1];
            end
            if (seen_count != '1) begin
                seen_count = seen_count + 1'b1;
            end
            if (!it.last_byte) begin
                return;
            end
            trav = (found & pss_pkg::GROUP_TRAVERSAL) != '0;
            cmd = (found & pss_pkg::GROUP_COMMAND) != '0;
            proto = (found & pss_pkg::GROUP_PROTOCOL) == pss_pkg::GROUP_PROTOCOL;
            sig = (found & pss_pkg::GROUP_SIGNATURE) != '0;
            proto_sum = (trav ? 45 : 0) + (proto ? 70 : 0);
            if (proto_sum > 100) begin
                proto_sum = 100;
            end
            want.hard_rule_score = (trav || cmd) ? 7'd100 : 7'd0;
            want.protocol_score = proto_sum[pss_pkg::SCORE_WIDTH-1:0];
            want.consequence_score = cmd ? 7'd80 : 7'd0;
            want.signature_score = sig ? 7'd100 : 7'd0;
            want.novelty_score = (seen_count > COUNT_W'(size_limit)) ? 7'd20 : 7'd0;
            want.reason_bits = '0;
            want.reason_bits[pss_pkg::REASON_TRAVERSAL] = trav;
            want.reason_bits[pss_pkg::REASON_COMMAND] = cmd;
            want.reason_bits[pss_pkg::REASON_PROTOCOL] = proto;
            want.reason_bits[pss_pkg::REASON_SIGNATURE] = sig;
            pending_scores.insert(pending_scores.size(), want);
            clear_payload();
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s expected %0d actual %0d", name, want, got);
                faults++;
            end
        endfunction

        function void check_score(pss_pkg::pss_result_t got);
            pss_pkg::pss_result_t want;
            if (pending_scores.size() == 0) begin
                $error("score item arrived with none pending");
                faults++;
                return;
            end
            want = pending_scores.pop_front();
            check_field("hard_rule_score", want.hard_rule_score, got.hard_rule_score);
            check_field("protocol_score", want.protocol_score, got.protocol_score);
            check_field("consequence_score", want.consequence_score, got.consequence_score);
            check_field("signature_score", want.signature_score, got.signature_score);
            check_field("novelty_score", want.novelty_score, got.novelty_score);
            check_field("reason_bits", want.reason_bits, got.reason_bits);
        endfunction
    endclass

    score_board sb = new();

    // clock
    initial begin
        forever #4 aclk = ~aclk;
    end

    // both handshakes are stable from one rising edge to the next,
    // so sample them in the middle of the cycle
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.absorb_byte(s_item);
            end
            if (m_valid && m_ready) begin
                sb.check_score(m_item);
            end
        end
    end

    // result side back-pressure
    initial begin
        forever begin
            @(posedge aclk);
            if (receiver_gaps && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // present one byte and hold it until accepted
    task automatic send_item(input logic [7:0] b, input logic last);
        pss_pkg::pss_item_t it;
        logic took;
        it.payload_byte = b;
        it.last_byte = last;
        s_valid <= 1'b1;
        s_item <= it;
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
        bytes_sent++;
        if (sender_gaps && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    task automatic send_bytes(ref logic [7:0] body [$]);
        for (int i = 0; i < body.size(); i++) begin
            send_item(body[i], i == body.size() - 1);
        end
        payloads_sent++;
    endtask

    task automatic send_text(input string s);
        logic [7:0] body [$];
        for (int i = 0; i < s.len(); i++) begin
            body.insert(body.size(), s[i]);
        end
        send_bytes(body);
    endtask

    task automatic add_filler(ref logic [7:0] body [$], input int unsigned count);
        for (int i = 0; i < count; i++) begin
            body.insert(body.size(), 8'($urandom_range(0, 255)));
        end
    endtask

    // needle with each letter in random case
    task automatic add_needle(ref logic [7:0] body [$], input int unsigned k);
        string n;
        logic [7:0] c;
        n = sb.needle_text(k);
        for (int i = 0; i < n.len(); i++) begin
            c = n[i];
            if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1) == 1) begin
                c = c - 8'd32;
            end
            body.insert(body.size(), c);
        end
    endtask

    // mostly needles in random filler, some noise and damaged needles
    task automatic send_random_payload();
        logic [7:0] body [$];
        string n;
        int unsigned kind;
        int unsigned spot;
        kind = $urandom_range(0, 9);
        if (kind <= 6) begin
            add_filler(body, $urandom_range(0, 8));
            add_needle(body, $urandom_range(0, pss_pkg::NEEDLE_COUNT - 1));
            if ($urandom_range(0, 3) == 0) begin
                add_needle(body, NEEDLE_CONTENT_LENGTH);
                add_filler(body, $urandom_range(0, 3));
                add_needle(body, NEEDLE_TRANSFER_ENCODING);
            end
            add_filler(body, $urandom_range(0, 4));
        end else if (kind == 7) begin
            add_filler(body, $urandom_range(1, 30));
        end else if (kind == 8) begin
            n = sb.needle_text($urandom_range(0, pss_pkg::NEEDLE_COUNT - 1));
            spot = $urandom_range(0, n.len() - 1);
            add_filler(body, $urandom_range(0, 3));
            for (int i = 0; i < n.len(); i++) begin
                if (i != spot) begin
                    body.insert(body.size(), n[i]);
                end else if ($urandom_range(0, 1) == 1) begin
                    body.insert(body.size(), n[i] ^ 8'h04);
                end
            end
        end else begin
            add_filler(body, 1);
        end
        send_bytes(body);
    endtask

    task automatic random_phase(input int unsigned byte_goal);
        while (bytes_sent < byte_goal) begin
            send_random_payload();
        end
    endtask

    // let every owed score come out before touching the register
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending_scores.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [pss_pkg::APB_ADDR_WIDTH-1:0] addr,
                             input logic [31:0] data);
        logic rdy;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do begin
            @(negedge aclk);
            rdy = pready;
            @(posedge aclk);
        end while (!rdy);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.write_reg(addr, data);
        if (addr == ADDR_SIZE_LIMIT) begin
            limits_used++;
        end
        @(posedge aclk);
    endtask

    task automatic check_limit_readback();
        logic rdy;
        logic [pss_pkg::APB_DATA_WIDTH-1:0] got;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_SIZE_LIMIT;
        @(posedge aclk);
        penable <= 1'b1;
        do begin
            @(negedge aclk);
            rdy = pready;
            got = prdata;
            @(posedge aclk);
        end while (!rdy);
        psel <= 1'b0;
        penable <= 1'b0;
        sb.check_field("large_size_limit", sb.size_limit, got);
        @(posedge aclk);
    endtask

    task automatic send_filler_payload(input int unsigned len);
        logic [7:0] body [$];
        add_filler(body, len);
        send_bytes(body);
    endtask

    // main sequence
    initial begin
        int unsigned lim;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        check_limit_readback();

        // directed payloads at the reset limit
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b1);
        send_text("../");
        send_text("..%2F");
        send_text("x%2E%2e");
        send_text("CMD.EXE");
        send_text("run PowerShell -c");
        send_text("/BIN/sh");
        send_text("MsHtA");
        send_text("Content-Length: 12");
        send_text("content-length: 5\ntransfer-encoding: chunked");
        send_text("GET ../ Content-Length:0 Transfer-Encoding: Chunked");
        send_text("${jndi:LDAP://x}");
        send_text("METERPRETER");
        send_text("mimiKatz");
        // characters at and just outside the folded range
        send_text("@[`{Z");
        // needles split over two payloads never match
        send_text("cmd.ex");
        send_text("e");
        send_text("..%2");
        send_text("f");
        send_text("../cmd.exe/jndi:ldap");
        drain();

        // limit zero: every payload is oversized
        apb_write(ADDR_SIZE_LIMIT, 32'd0);
        check_limit_readback();
        random_phase(bytes_sent + 130);
        drain();

        // writes to an unmapped offset leave the limit alone
        apb_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
        check_limit_readback();

        // all ones: upper bits dropped, limit at its maximum
        apb_write(ADDR_SIZE_LIMIT, 32'hFFFF_FFFF);
        check_limit_readback();
        random_phase(bytes_sent + 130);
        drain();

        // small limit with junk in the upper bits, payloads right at the edge
        lim = $urandom_range(1, 40);
        apb_write(ADDR_SIZE_LIMIT, 32'hFFF0_0000 | lim);
        check_limit_readback();
        send_filler_payload(lim);
        send_filler_payload(lim + 1);
        random_phase(bytes_sent + 130);
        drain();

        // last stretch at full rate
        sender_gaps = 1'b0;
        receiver_gaps = 1'b0;
        apb_write(ADDR_SIZE_LIMIT, $urandom_range(0, 63));
        check_limit_readback();
        random_phase(bytes_sent + 170);
        drain();
        repeat (10) @(posedge aclk);

        $display("covered %0d payloads and %0d bytes over %0d limit settings",
            payloads_sent, bytes_sent, limits_used + 1);
        if (sb.faults == 0 && sb.pending_scores.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("watchdog expired with %0d scores pending", sb.pending_scores.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/pss_pkg.sv
src/pss_regs.sv
src/pss_match.sv
src/payload_signature_scorer_top.sv
tb/sv/payload_signature_scorer_top_tb.sv
